FILE: rtl/apfr_pkg.sv
// types, constants and helper functions shared by the alarm panel frame receiver
package apfr_pkg;

    // framing bytes and command codes
    localparam logic [7:0] START_BYTE     = 8'hF0;
    localparam logic [7:0] CMD_RESET      = 8'hA1;
    localparam logic [7:0] CMD_POLL       = 8'hA2;
    localparam logic [7:0] CMD_TIME       = 8'hA4;
    localparam logic [7:0] CMD_EVENT      = 8'hA5;
    localparam logic [7:0] REPLY_LEN_BYTE = 8'h03;
    localparam logic [7:0] REPLY_PAD_BYTE = 8'h00;

    // panel status byte codes
    localparam logic [7:0] PANEL_ST_NORMAL = 8'h00;
    localparam logic [7:0] PANEL_ST_FIRE   = 8'h05;
    localparam logic [7:0] PANEL_ST_LOST   = 8'h01;

    // info type codes that carry a location
    localparam logic [7:0] INFO_LOC_A = 8'h01;
    localparam logic [7:0] INFO_LOC_B = 8'h02;
    localparam logic [7:0] INFO_LOC_C = 8'h08;

    // reported event status codes
    localparam logic [1:0] EVT_ST_NONE   = 2'd0;
    localparam logic [1:0] EVT_ST_NORMAL = 2'd1;
    localparam logic [1:0] EVT_ST_FIRE   = 2'd2;
    localparam logic [1:0] EVT_ST_LOST   = 2'd3;

    // frame lengths in bytes, start byte included
    localparam logic [8:0] LEN_SHORT     = 9'd6;
    localparam logic [8:0] LEN_TIME      = 9'd12;
    localparam logic [8:0] LEN_EVT_SHORT = 9'd25;
    localparam logic [8:0] LEN_EVT_LONG  = 9'd45;
    localparam logic [8:0] LEN_OVERHEAD  = 9'd5;

    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [7:0]  LINK_TIMEOUT_RST = 8'd40;
    localparam logic [2:0]  REPLY_LAST_IDX   = 3'd7;

    // result kinds, also used as job kinds between front and back
    typedef enum logic [2:0] {
        KIND_RESET = 3'd0,
        KIND_REPLY = 3'd1,
        KIND_TIME  = 3'd2,
        KIND_EVENT = 3'd3,
        KIND_LOST  = 3'd4
    } out_kind_t;

    // work handed from the frame parser to the result sequencer
    typedef struct packed {
        out_kind_t   kind;
        logic [7:0]  addr;
        logic [1:0]  status;
        logic [31:0] part;
        logic [47:0] stamp;
        logic [7:0]  device;
        logic [23:0] loc;
        logic        has_loc;
    } apfr_job_t;

    typedef enum logic {
        BK_IDLE,
        BK_REPLY
    } bk_state_t;

    // one byte of crc-16/xmodem
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // panel status byte to reported status
    function automatic logic [1:0] map_status(input logic [7:0] st);
        logic [1:0] r;
        case (st)
            PANEL_ST_NORMAL: r = EVT_ST_NORMAL;
            PANEL_ST_FIRE:   r = EVT_ST_FIRE;
            PANEL_ST_LOST:   r = EVT_ST_LOST;
            default:         r = EVT_ST_NONE;
        endcase
        return r;
    endfunction

    function automatic logic info_has_loc(input logic [7:0] info);
        return info inside {INFO_LOC_A, INFO_LOC_B, INFO_LOC_C};
    endfunction

endpackage

FILE: rtl/alarm_panel_frame_receiver.sv
// top level of the alarm panel frame receiver: parser, job queue, result sequencer
//
//  channel   direction  transfer               payload
//  s_axis    in         one byte or one tick   tdata rx_byte, tuser req_type
//  m_axis    out        one result item        tdata fields, tuser out_kind, tlast
//  cfg       in         write of timeout       cfg_wdata link_timeout_ticks
//
//  the parser takes one input transfer per cycle while s_axis_tready is high
//  results leave at one per cycle while m_axis_tready is high; a poll reply holds the sequencer until its last byte
//  the job queue (QUEUE_DEPTH entries) lets input run on while results stall
//  s_axis_tready drops only when the queue is full
//  reset clears the parser, queue and sequencer at once; no clearing pass
module alarm_panel_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]   s_axis_tuser,   // [0] req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [7:0] tx_byte, [9:8] event_status,
                                         // [41:10] part_address, [89:42] time_stamp,
                                         // [97:90] device_type, [121:98] location,
                                         // [122] has_location, [127:123] zero
    output logic [2:0]   m_axis_tuser,   // [2:0] out_kind
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);
    import apfr_pkg::*;

    logic      [7:0] timeout_reg;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    apfr_job_t       push_job;
    apfr_job_t       head_job;
    apfr_job_t       out_job;
    logic      [7:0] out_tx;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= LINK_TIMEOUT_RST;
        else if (cfg_we)
            timeout_reg <= cfg_wdata;
    end

    apfr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .req_type      (s_axis_tuser[0]),
        .rx_byte       (s_axis_tdata),
        .timeout_ticks (timeout_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    apfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    apfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_job   (out_job),
        .out_tx    (out_tx),
        .out_last  (m_axis_tlast)
    );

    // result packing
    assign m_axis_tuser = out_job.kind;
    assign m_axis_tdata = {5'd0, out_job.has_loc, out_job.loc, out_job.device,
                           out_job.stamp, out_job.part, out_job.status, out_tx};

    // queue cannot be full and empty together
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("job queue full and empty at once");

    // every result other than a reply byte closes its item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_REPLY)) |-> m_axis_tlast)
        else $error("single result without tlast");

    // a reply run continues without a gap until its last byte
    a_reply_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_REPLY) && !m_axis_tlast)
        |=> (m_axis_tvalid && (m_axis_tuser == KIND_REPLY)))
        else $error("poll reply interrupted");

endmodule

FILE: rtl/apfr_front.sv
// frame parser: hunts for start, captures fields, turns finished frames and timeouts into jobs
module apfr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        timeout_ticks,
    input  logic              q_full,
    output logic              q_push,
    output apfr_pkg::apfr_job_t q_job
);
    import apfr_pkg::*;

    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  total_reg, total_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  info_reg, info_next;
    logic [31:0] part_reg, part_next;
    logic [47:0] time_reg, time_next;
    logic [7:0]  dev_reg, dev_next;
    logic [23:0] loc_reg, loc_next;
    logic [7:0]  timer_reg, timer_next;

    logic       accept;
    logic       frame_end;
    logic [7:0] cmd_eff;
    logic       loc_ok;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cmd_eff  = (pos_reg == 9'd3) ? rx_byte : cmd_reg;
    assign loc_ok   = info_has_loc(info_reg);
    assign frame_end = (pos_reg >= 9'd3) &&
                       (({1'b0, pos_reg} + 10'd1) >= {1'b0, total_reg});

    // parser next state and job build
    always_comb
    begin
        pos_next    = pos_reg;
        total_next  = total_reg;
        addr_next   = addr_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        info_next   = info_reg;
        part_next   = part_reg;
        time_next   = time_reg;
        dev_next    = dev_reg;
        loc_next    = loc_reg;
        timer_next  = timer_reg;
        q_push      = 1'b0;
        q_job       = '0;

        if (accept)
        begin
            if (req_type)
            begin
                // empty tick counts the link timer down; at expiry it reloads and pushes a lost job
                if (timer_reg <= 8'd1)
                begin
                    timer_next = timeout_ticks;
                    q_push     = 1'b1;
                    q_job.kind = KIND_LOST;
                end
                else
                begin
                    timer_next = timer_reg - 8'd1;
                end
            end
            else
            begin
                timer_next = timeout_ticks;
                if (pos_reg == 9'd0)
                begin
                    // hunting for start byte
                    if (rx_byte == START_BYTE)
                    begin
                        pos_next    = 9'd1;
                        total_next  = '0;
                        addr_next   = '0;
                        cmd_next    = '0;
                        status_next = '0;
                        info_next   = '0;
                        part_next   = '0;
                        time_next   = '0;
                        dev_next    = '0;
                        loc_next    = '0;
                    end
                end
                else
                begin
                    // header bytes and field capture
                    case (pos_reg)
                        9'd1:    addr_next  = rx_byte;
                        9'd2:    total_next = {1'b0, rx_byte} + LEN_OVERHEAD;
                        9'd3:    cmd_next   = rx_byte;
                        default:
                        begin
                            if (pos_reg == 9'd5)
                                info_next = rx_byte;
                            if (pos_reg == 9'd6)
                                status_next = rx_byte;
                            if (cmd_reg == CMD_TIME)
                            begin
                                if (pos_reg inside {[9'd4:9'd9]})
                                    time_next = {time_reg[39:0], rx_byte};
                            end
                            else if (cmd_reg == CMD_EVENT)
                            begin
                                if (pos_reg inside {[9'd9:9'd14]})
                                    time_next = {time_reg[39:0], rx_byte};
                                if (pos_reg inside {9'd8, 9'd15, 9'd16, 9'd20})
                                    part_next = {part_reg[23:0], rx_byte};
                                if (pos_reg inside {[9'd17:9'd19]})
                                    loc_next = {loc_reg[15:0], rx_byte};
                                if (pos_reg == 9'd22)
                                    dev_next = rx_byte;
                            end
                        end
                    endcase

                    // frame finish: command and length decide the job
                    if (frame_end)
                    begin
                        pos_next = 9'd0;
                        case (cmd_eff)
                            CMD_RESET:
                            begin
                                if (total_reg == LEN_SHORT)
                                begin
                                    q_push     = 1'b1;
                                    q_job.kind = KIND_RESET;
                                end
                            end
                            CMD_POLL:
                            begin
                                if (total_reg == LEN_SHORT)
                                begin
                                    q_push     = 1'b1;
                                    q_job.kind = KIND_REPLY;
                                    q_job.addr = addr_reg;
                                end
                            end
                            CMD_TIME:
                            begin
                                if (total_reg == LEN_TIME)
                                begin
                                    q_push      = 1'b1;
                                    q_job.kind  = KIND_TIME;
                                    q_job.stamp = time_reg;
                                end
                            end
                            CMD_EVENT:
                            begin
                                if (total_reg inside {LEN_EVT_SHORT, LEN_EVT_LONG})
                                begin
                                    q_push        = 1'b1;
                                    q_job.kind    = KIND_EVENT;
                                    q_job.status  = map_status(status_reg);
                                    q_job.part    = part_reg;
                                    q_job.stamp   = time_reg;
                                    q_job.device  = loc_ok ? dev_reg : 8'd0;
                                    q_job.loc     = loc_ok ? loc_reg : 24'd0;
                                    q_job.has_loc = loc_ok;
                                end
                            end
                            default:
                            begin
                                q_push = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        pos_next = pos_reg + 9'd1;
                    end
                end
            end
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            total_reg  <= '0;
            addr_reg   <= '0;
            cmd_reg    <= '0;
            status_reg <= '0;
            info_reg   <= '0;
            part_reg   <= '0;
            time_reg   <= '0;
            dev_reg    <= '0;
            loc_reg    <= '0;
            timer_reg  <= LINK_TIMEOUT_RST;
        end
        else
        begin
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            info_reg   <= info_next;
            part_reg   <= part_next;
            time_reg   <= time_next;
            dev_reg    <= dev_next;
            loc_reg    <= loc_next;
            timer_reg  <= timer_next;
        end
    end

endmodule

FILE: rtl/apfr_queue.sv
// small job queue between the parser and the result sequencer
module apfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  apfr_pkg::apfr_job_t push_job,
    input  logic                pop,
    output apfr_pkg::apfr_job_t head_job,
    output logic                full,
    output logic                empty
);
    import apfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    apfr_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: rtl/apfr_back.sv
// result sequencer: expands jobs into result transfers, builds the poll reply and its crc
module apfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  apfr_pkg::apfr_job_t q_job,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output apfr_pkg::apfr_job_t out_job,
    output logic [7:0]          out_tx,
    output logic                out_last
);
    import apfr_pkg::*;

    bk_state_t   state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  addr_reg, addr_next;
    logic        valid_reg, valid_next;
    apfr_job_t   job_reg, job_next;
    logic [7:0]  tx_reg, tx_next;
    logic        last_reg, last_next;
    logic        load;
    logic [7:0]  reply_byte;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_job   = job_reg;
    assign out_tx    = tx_reg;
    assign out_last  = last_reg;

    // reply byte for the current index
    always_comb
    begin
        case (idx_reg)
            3'd0:    reply_byte = START_BYTE;
            3'd1:    reply_byte = addr_reg;
            3'd2:    reply_byte = REPLY_LEN_BYTE;
            3'd3:    reply_byte = CMD_POLL;
            3'd4:    reply_byte = REPLY_PAD_BYTE;
            3'd5:    reply_byte = REPLY_PAD_BYTE;
            3'd6:    reply_byte = crc_reg[15:8];
            default: reply_byte = crc_reg[7:0];
        endcase
    end

    // sequencer next state and output register load
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        addr_next  = addr_reg;
        valid_next = valid_reg && !out_ready;
        job_next   = job_reg;
        tx_next    = tx_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (load && !q_empty)
                begin
                    q_pop      = 1'b1;
                    valid_next = 1'b1;
                    job_next   = q_job;
                    if (q_job.kind == KIND_REPLY)
                    begin
                        // first reply byte goes out now, rest follow
                        job_next      = '0;
                        job_next.kind = KIND_REPLY;
                        tx_next       = START_BYTE;
                        last_next     = 1'b0;
                        idx_next      = 3'd1;
                        crc_next      = '0;
                        addr_next     = q_job.addr;
                        state_next    = BK_REPLY;
                    end
                    else
                    begin
                        tx_next   = 8'd0;
                        last_next = 1'b1;
                    end
                end
            end
            BK_REPLY:
            begin
                if (load)
                begin
                    valid_next    = 1'b1;
                    job_next      = '0;
                    job_next.kind = KIND_REPLY;
                    tx_next       = reply_byte;
                    last_next     = (idx_reg == REPLY_LAST_IDX);
                    // crc covers address through the two pad bytes
                    if (idx_reg inside {[3'd1:3'd5]})
                        crc_next = crc_step(crc_reg, reply_byte);
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == REPLY_LAST_IDX)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        crc_reg  <= crc_next;
        addr_reg <= addr_next;
        job_reg  <= job_next;
        tx_reg   <= tx_next;
        last_reg <= last_next;
    end

endmodule
